// ===== rtl/core/crv_pkg.sv =====
// ----------------------------------------------------------------------------
// crv_pkg
// Shared types, defaults and constant tables for the CORDIC rotate/vector unit.
// ----------------------------------------------------------------------------
package crv_pkg;

  localparam int ITERATIONS_DEF = 20;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 29;
  localparam int FIELD_WIDTH    = 32;

  localparam int GAIN_STEPS = 7;
  localparam int GAIN_SHIFT [GAIN_STEPS] = '{1, 2, 5, 10, 16, 19, 22};
  // bit g set: step g subtracts the shifted value, otherwise adds it
  localparam logic [GAIN_STEPS-1:0] GAIN_SUB = 7'b0000101;

  localparam logic [63:0] ONE_Q62 = 64'd1 << 62;

  typedef enum logic {
    CMD_ROTATE = 1'b0,
    CMD_VECTOR = 1'b1
  } crv_cmd_t;

  typedef struct packed {
    crv_cmd_t           cmd;
    logic signed [31:0] target_angle;
    logic signed [31:0] x_in;
    logic signed [31:0] y_in;
  } crv_in_t;

  typedef struct packed {
    logic signed [31:0] angle_out;
    logic signed [31:0] sin_out;
    logic signed [31:0] cos_out;
  } crv_out_t;

  typedef struct packed {
    logic     valid;
    crv_cmd_t vec;
  } crv_ctrl_t;

  // p / (2k + 1) for the odd divisors the series needs
  function automatic logic [63:0] div_odd(logic [63:0] p, int k);
    case (k)
      0:       return p;
      1:       return p / 3;
      2:       return p / 5;
      3:       return p / 7;
      4:       return p / 9;
      5:       return p / 11;
      6:       return p / 13;
      7:       return p / 15;
      8:       return p / 17;
      9:       return p / 19;
      10:      return p / 21;
      11:      return p / 23;
      12:      return p / 25;
      13:      return p / 27;
      14:      return p / 29;
      15:      return p / 31;
      16:      return p / 33;
      17:      return p / 35;
      18:      return p / 37;
      19:      return p / 39;
      20:      return p / 41;
      21:      return p / 43;
      22:      return p / 45;
      23:      return p / 47;
      24:      return p / 49;
      25:      return p / 51;
      26:      return p / 53;
      27:      return p / 55;
      28:      return p / 57;
      29:      return p / 59;
      30:      return p / 61;
      default: return 64'd0;
    endcase
  endfunction

  // atan(1/5) or atan(1/239) at 62 fraction bits, Gregory series
  function automatic logic [63:0] atan_recip_q62(logic use239);
    logic [63:0] p;
    logic [63:0] acc;
    logic [63:0] t;
    p   = use239 ? ONE_Q62 / 239 : ONE_Q62 / 5;
    acc = 64'd0;
    for (int k = 0; k < 64; k++) begin
      if (p != 64'd0) begin
        t = div_odd(p, k);
        if (k[0]) acc = acc - t;
        else acc = acc + t;
        p = use239 ? p / 57121 : p / 25;
      end
    end
    return acc;
  endfunction

  // atan(2^-i) at 62 fraction bits
  function automatic logic [63:0] atan_pow2_q62(int i);
    logic [63:0] acc;
    logic [63:0] t;
    int          sh;
    acc = 64'd0;
    if (i == 0) begin
      return (64'd4 * atan_recip_q62(1'b0)) - atan_recip_q62(1'b1);
    end
    for (int k = 0; k < 32; k++) begin
      sh = i * (2 * k + 1);
      if (sh <= 62) begin
        t = div_odd(ONE_Q62 >> sh, k);
        if (k[0]) acc = acc - t;
        else acc = acc + t;
      end
    end
    return acc;
  endfunction

  // atan(2^-i) rounded to nearest at frac fraction bits
  function automatic logic [63:0] angle_entry(int i, int frac);
    logic [63:0] a;
    a = atan_pow2_q62(i);
    return (a + (64'd1 << (61 - frac))) >> (62 - frac);
  endfunction

endpackage

// ===== rtl/core/crv_iter_stage.sv =====
// ----------------------------------------------------------------------------
// crv_iter_stage
// One registered CORDIC micro-rotation by atan(2^-INDEX).
// ----------------------------------------------------------------------------
module crv_iter_stage #(
  parameter int DATA_WIDTH = crv_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = crv_pkg::FRAC_BITS_DEF,
  parameter int INDEX      = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  crv_pkg::crv_ctrl_t            ctrl,
  input  logic signed [DATA_WIDTH-1:0]  x,
  input  logic signed [DATA_WIDTH-1:0]  y,
  input  logic signed [DATA_WIDTH-1:0]  theta,
  input  logic signed [DATA_WIDTH-1:0]  z,
  output crv_pkg::crv_ctrl_t            ctrl_step,
  output logic signed [DATA_WIDTH-1:0]  x_step,
  output logic signed [DATA_WIDTH-1:0]  y_step,
  output logic signed [DATA_WIDTH-1:0]  theta_step,
  output logic signed [DATA_WIDTH-1:0]  z_step
);

  localparam logic signed [DATA_WIDTH-1:0] ANGLE =
    DATA_WIDTH'(crv_pkg::angle_entry(INDEX, FRAC_BITS));

  logic                         neg;
  logic                         widen;
  logic signed [DATA_WIDTH-1:0] xs;
  logic signed [DATA_WIDTH-1:0] ys;
  logic signed [DATA_WIDTH-1:0] x_next;
  logic signed [DATA_WIDTH-1:0] y_next;
  logic signed [DATA_WIDTH-1:0] theta_next;
  logic signed [DATA_WIDTH-1:0] z_next;

  always_comb begin
    neg   = (ctrl.vec == crv_pkg::CMD_VECTOR) ? y[DATA_WIDTH-1] : z[DATA_WIDTH-1];
    widen = neg != (ctrl.vec == crv_pkg::CMD_VECTOR);
    xs    = x >>> INDEX;
    ys    = y >>> INDEX;
    if (neg) begin
      x_next = x - ys;
      y_next = y + xs;
    end else begin
      x_next = x + ys;
      y_next = y - xs;
    end
    if (widen) begin
      theta_next = theta + ANGLE;
      z_next     = z + ANGLE;
    end else begin
      theta_next = theta - ANGLE;
      z_next     = z - ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_step <= '0;
    end else begin
      ctrl_step <= ctrl;
    end
  end

  always_ff @(posedge clk) begin
    x_step     <= x_next;
    y_step     <= y_next;
    theta_step <= theta_next;
    z_step     <= z_next;
  end

endmodule

// ===== rtl/core/crv_gain_stage.sv =====
// ----------------------------------------------------------------------------
// crv_gain_stage
// One registered shift-add gain correction step applied to x and y.
// ----------------------------------------------------------------------------
module crv_gain_stage #(
  parameter int   DATA_WIDTH = crv_pkg::DATA_WIDTH_DEF,
  parameter int   SHIFT      = 1,
  parameter logic SUBTRACT   = 1'b0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  crv_pkg::crv_ctrl_t            ctrl,
  input  logic signed [DATA_WIDTH-1:0]  x,
  input  logic signed [DATA_WIDTH-1:0]  y,
  input  logic signed [DATA_WIDTH-1:0]  theta,
  output crv_pkg::crv_ctrl_t            ctrl_scaled,
  output logic signed [DATA_WIDTH-1:0]  x_scaled,
  output logic signed [DATA_WIDTH-1:0]  y_scaled,
  output logic signed [DATA_WIDTH-1:0]  theta_scaled
);

  logic signed [DATA_WIDTH-1:0] x_next;
  logic signed [DATA_WIDTH-1:0] y_next;

  always_comb begin
    if (SUBTRACT) begin
      x_next = x - (x >>> SHIFT);
      y_next = y - (y >>> SHIFT);
    end else begin
      x_next = x + (x >>> SHIFT);
      y_next = y + (y >>> SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_scaled <= '0;
    end else begin
      ctrl_scaled <= ctrl;
    end
  end

  always_ff @(posedge clk) begin
    x_scaled     <= x_next;
    y_scaled     <= y_next;
    theta_scaled <= theta;
  end

endmodule

// ===== rtl/core/cordic_rotate_vector_unit.sv =====
// ----------------------------------------------------------------------------
// cordic_rotate_vector_unit
// Fully pipelined CORDIC for sine/cosine (rotation) and magnitude/arctangent
// (vectoring).
// ----------------------------------------------------------------------------
// Raise start with a command beat on item; it is taken at any edge where busy
// is low. busy is high only while rst is held, so one beat may enter every
// clock cycle, independent of earlier beats still in flight.
// Each beat passes one input register, ITERATIONS micro-rotation stages and
// seven gain correction stages, one register each. Its result appears on
// result with done high for exactly one cycle once it has left the last
// gain correction stage; the depth of the micro-rotation and gain chain
// sets when it appears. Results leave in accept order.
// Throughput is one beat per cycle.
// Reset empties the pipeline: beats in flight are dropped and done stays low
// until new beats arrive. The receiver cannot stall; each result is
// presented once and must be taken in that cycle.
// ----------------------------------------------------------------------------
module cordic_rotate_vector_unit #(
  parameter int ITERATIONS = crv_pkg::ITERATIONS_DEF,
  parameter int DATA_WIDTH = crv_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = crv_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  crv_pkg::crv_in_t  item,
  output logic              done,
  output crv_pkg::crv_out_t result
);

  localparam int LAST = ITERATIONS + crv_pkg::GAIN_STEPS;
  localparam int LAT  = LAST + 1;

  crv_pkg::crv_ctrl_t           ctrl_pipe  [0:LAST];
  logic signed [DATA_WIDTH-1:0] x_pipe     [0:LAST];
  logic signed [DATA_WIDTH-1:0] y_pipe     [0:LAST];
  logic signed [DATA_WIDTH-1:0] theta_pipe [0:LAST];
  logic signed [DATA_WIDTH-1:0] z_pipe     [0:ITERATIONS];

  logic                         accept;
  logic signed [DATA_WIDTH-1:0] target_ext;

  assign busy       = rst;
  assign accept     = start && !busy;
  assign target_ext = DATA_WIDTH'(item.target_angle);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_pipe[0] <= '0;
    end else begin
      ctrl_pipe[0].valid <= accept;
      ctrl_pipe[0].vec   <= item.cmd;
    end
  end

  always_ff @(posedge clk) begin
    x_pipe[0]     <= DATA_WIDTH'(item.x_in);
    y_pipe[0]     <= DATA_WIDTH'(item.y_in);
    theta_pipe[0] <= '0;
    z_pipe[0]     <= '0 - target_ext;
  end

  for (genvar k = 0; k < ITERATIONS; k++) begin : g_iter
    crv_iter_stage #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS),
      .INDEX      (k)
    ) u_iter (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl_pipe[k]),
      .x          (x_pipe[k]),
      .y          (y_pipe[k]),
      .theta      (theta_pipe[k]),
      .z          (z_pipe[k]),
      .ctrl_step  (ctrl_pipe[k+1]),
      .x_step     (x_pipe[k+1]),
      .y_step     (y_pipe[k+1]),
      .theta_step (theta_pipe[k+1]),
      .z_step     (z_pipe[k+1])
    );
  end

  for (genvar g = 0; g < crv_pkg::GAIN_STEPS; g++) begin : g_gain
    crv_gain_stage #(
      .DATA_WIDTH (DATA_WIDTH),
      .SHIFT      (crv_pkg::GAIN_SHIFT[g]),
      .SUBTRACT   (crv_pkg::GAIN_SUB[g])
    ) u_gain (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl_pipe[ITERATIONS+g]),
      .x            (x_pipe[ITERATIONS+g]),
      .y            (y_pipe[ITERATIONS+g]),
      .theta        (theta_pipe[ITERATIONS+g]),
      .ctrl_scaled  (ctrl_pipe[ITERATIONS+g+1]),
      .x_scaled     (x_pipe[ITERATIONS+g+1]),
      .y_scaled     (y_pipe[ITERATIONS+g+1]),
      .theta_scaled (theta_pipe[ITERATIONS+g+1])
    );
  end

  assign done             = ctrl_pipe[LAST].valid;
  assign result.angle_out = 32'(theta_pipe[LAST]);
  assign result.sin_out   = 32'(y_pipe[LAST]);
  assign result.cos_out   = 32'(x_pipe[LAST]);

  a_done_follows_accept : assert property (
    @(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT)
  ) else $error("result strobe without a matching accepted beat");

  a_zero_vector : assert property (
    @(posedge clk) disable iff (rst)
    (done && $past(accept && item.cmd == crv_pkg::CMD_VECTOR &&
                   item.x_in == 32'sd0 && item.y_in == 32'sd0, LAT))
    |-> (result.sin_out == 32'sd0 && result.cos_out == 32'sd0)
  ) else $error("zero vector did not stay zero");

  a_residual_tracks_angle : assert property (
    @(posedge clk) disable iff (rst)
    (ctrl_pipe[ITERATIONS].valid && ctrl_pipe[ITERATIONS].vec == crv_pkg::CMD_ROTATE &&
     $past(accept, ITERATIONS + 1))
    |-> (z_pipe[ITERATIONS] ==
         theta_pipe[ITERATIONS] - DATA_WIDTH'($past(item.target_angle, ITERATIONS + 1)))
  ) else $error("angle residual out of step with accumulated angle");

  a_reset_flushes : assert property (
    @(posedge clk)
    rst |=> !done
  ) else $error("result strobe right after reset");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Regression for cordic_rotate_vector_unit: drives rotation and vectoring
// beats with random idle bursts, predicts each result with an independent
// bit-exact CORDIC computation, and checks results in accept order.
// ----------------------------------------------------------------------------
localparam int CORDIC_STAGES = crv_pkg::ITERATIONS_DEF;
localparam int ANGLE_FRAC    = crv_pkg::FRAC_BITS_DEF;
localparam int PIPE_LATENCY  = CORDIC_STAGES + 8;

class cordic_scoreboard;
  logic signed [31:0] arc_table [CORDIC_STAGES];
  crv_pkg::crv_out_t  pending_results [$];
  int unsigned        faults;

  function new();
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      arc_table[i] = round_arc(atan_pow2(i));
    end
    faults = 0;
  endfunction

  // atan(1/n) at 62 fraction bits
  function logic [63:0] gregory_inv(logic [63:0] n);
    logic [63:0] pw;
    logic [63:0] sum;
    logic [63:0] term;
    int          k;
    pw  = (64'd1 << 62) / n;
    sum = 64'd0;
    k   = 0;
    while (pw != 64'd0) begin
      term = pw / 64'(2 * k + 1);
      if (k % 2 == 1) sum = sum - term;
      else sum = sum + term;
      pw = pw / (n * n);
      k++;
    end
    return sum;
  endfunction

  // atan(2^-i) at 62 fraction bits
  function logic [63:0] atan_pow2(int i);
    logic [63:0] sum;
    logic [63:0] term;
    int          k;
    sum = 64'd0;
    k   = 0;
    if (i == 0) return 64'd4 * gregory_inv(64'd5) - gregory_inv(64'd239);
    while (i * (2 * k + 1) <= 62) begin
      term = ((64'd1 << 62) >> (i * (2 * k + 1))) / 64'(2 * k + 1);
      if (k % 2 == 1) sum = sum - term;
      else sum = sum + term;
      k++;
    end
    return sum;
  endfunction

  function logic signed [31:0] round_arc(logic [63:0] a);
    logic [63:0] r;
    r = (a + (64'd1 << (61 - ANGLE_FRAC))) >> (62 - ANGLE_FRAC);
    return r[31:0];
  endfunction

  function logic signed [31:0] gain_trim(logic signed [31:0] v);
    v = v - (v >>> 1);
    v = v + (v >>> 2);
    v = v - (v >>> 5);
    v = v + (v >>> 10);
    v = v + (v >>> 16);
    v = v + (v >>> 19);
    v = v + (v >>> 22);
    return v;
  endfunction

  function crv_pkg::crv_out_t compute_cordic(crv_pkg::crv_in_t v);
    logic signed [31:0] xr;
    logic signed [31:0] yr;
    logic signed [31:0] xs;
    logic signed [31:0] ys;
    logic signed [31:0] th;
    logic signed [31:0] steer;
    logic               turn_neg;
    logic               vec;
    crv_pkg::crv_out_t  r;
    vec   = (v.cmd == crv_pkg::CMD_VECTOR);
    xr    = v.x_in;
    yr    = v.y_in;
    th    = '0;
    steer = vec ? yr : -v.target_angle;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      xs       = xr >>> i;
      ys       = yr >>> i;
      turn_neg = steer[31];
      if (turn_neg) begin
        xr = xr - ys;
        yr = yr + xs;
      end else begin
        xr = xr + ys;
        yr = yr - xs;
      end
      if (turn_neg != vec) th = th + arc_table[i];
      else th = th - arc_table[i];
      steer = vec ? yr : th - v.target_angle;
    end
    r.angle_out = th;
    r.sin_out   = gain_trim(yr);
    r.cos_out   = gain_trim(xr);
    return r;
  endfunction

  function void note_item(crv_pkg::crv_in_t v);
    pending_results.push_back(compute_cordic(v));
  endfunction

  function void check_result(crv_pkg::crv_out_t got);
    crv_pkg::crv_out_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      faults++;
      return;
    end
    want = pending_results.pop_front();
    if (got.angle_out !== want.angle_out) begin
      $display("%0t: angle_out expected %h actual %h", $time, want.angle_out, got.angle_out);
      faults++;
    end
    if (got.sin_out !== want.sin_out) begin
      $display("%0t: sin_out expected %h actual %h", $time, want.sin_out, got.sin_out);
      faults++;
    end
    if (got.cos_out !== want.cos_out) begin
      $display("%0t: cos_out expected %h actual %h", $time, want.cos_out, got.cos_out);
      faults++;
    end
  endfunction

  function int outstanding();
    return pending_results.size();
  endfunction
endclass

module tb;
  localparam logic signed [31:0] ONE_Q  = 32'sh2000_0000;
  localparam logic signed [31:0] PI_Q   = 32'sd1686629713;
  localparam logic signed [31:0] MAX_Q  = 32'sh7fff_ffff;
  localparam logic signed [31:0] MIN_Q  = 32'sh8000_0000;
  localparam int                 N_RAND = 900;
  localparam int                 N_CALM = 150;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  crv_pkg::crv_in_t  item;
  logic              done;
  crv_pkg::crv_out_t result;

  cordic_scoreboard cordic_sb;

  cordic_rotate_vector_unit u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("cordic_rotate_vector_unit regression: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done) cordic_sb.check_result(result);
      if (start && busy === 1'b0) cordic_sb.note_item(item);
    end
  end

  function automatic crv_pkg::crv_in_t mk(crv_pkg::crv_cmd_t c, logic signed [31:0] t,
                                          logic signed [31:0] x, logic signed [31:0] y);
    crv_pkg::crv_in_t v;
    v.cmd          = c;
    v.target_angle = t;
    v.x_in         = x;
    v.y_in         = y;
    return v;
  endfunction

  function automatic crv_pkg::crv_in_t random_beat();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      return mk(crv_pkg::CMD_ROTATE,
                32'($urandom_range(0, 32'd3373259426) - 32'd1686629713),
                ONE_Q - 32'($urandom_range(0, 255)), 32'($urandom_range(0, 3)) - 32'sd1);
    end
    if (pick < 7) begin
      return mk(crv_pkg::CMD_VECTOR, 32'($urandom()),
                32'($urandom_range(0, 32'h8000_0000) - 32'h4000_0000),
                32'($urandom_range(0, 32'h8000_0000) - 32'h4000_0000));
    end
    return mk(crv_pkg::crv_cmd_t'($urandom_range(0, 1)), 32'($urandom()), 32'($urandom()),
              32'($urandom()));
  endfunction

  task automatic send_beat(crv_pkg::crv_in_t v);
    start <= 1'b1;
    item  <= v;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic idle_gap(int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (cordic_sb.outstanding() != 0) @(posedge clk);
  endtask

  initial begin
    crv_pkg::crv_in_t directed [$];
    bit               calm;
    cordic_sb = new();
    rst   = 1'b1;
    start = 1'b0;
    item  = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed.push_back(mk(crv_pkg::CMD_ROTATE, '0, ONE_Q, '0));
    directed.push_back(mk(crv_pkg::CMD_ROTATE, 32'sd281104952, ONE_Q, '0));
    directed.push_back(mk(crv_pkg::CMD_ROTATE, 32'sd421657428, ONE_Q, '0));
    directed.push_back(mk(crv_pkg::CMD_ROTATE, 32'sd843314857, ONE_Q, '0));
    directed.push_back(mk(crv_pkg::CMD_ROTATE, -32'sd843314857, ONE_Q, '0));
    directed.push_back(mk(crv_pkg::CMD_ROTATE, PI_Q, ONE_Q, '0));
    directed.push_back(mk(crv_pkg::CMD_ROTATE, -PI_Q, ONE_Q, '0));
    directed.push_back(mk(crv_pkg::CMD_ROTATE, MAX_Q, ONE_Q, '0));
    directed.push_back(mk(crv_pkg::CMD_ROTATE, MIN_Q, ONE_Q, '0));
    directed.push_back(mk(crv_pkg::CMD_ROTATE, cordic_sb.arc_table[0], ONE_Q, '0));
    directed.push_back(mk(crv_pkg::CMD_ROTATE, 32'sd562209905, MIN_Q, MIN_Q));
    directed.push_back(mk(crv_pkg::CMD_ROTATE, -32'sd421657428, MAX_Q, MAX_Q));
    directed.push_back(mk(crv_pkg::CMD_ROTATE, 32'sd1, '0, ONE_Q));
    directed.push_back(mk(crv_pkg::CMD_ROTATE, -32'sd1, -32'sd1, '0));
    directed.push_back(mk(crv_pkg::CMD_VECTOR, '0, ONE_Q, '0));
    directed.push_back(mk(crv_pkg::CMD_VECTOR, '0, ONE_Q, ONE_Q));
    directed.push_back(mk(crv_pkg::CMD_VECTOR, '0, -ONE_Q, ONE_Q));
    directed.push_back(mk(crv_pkg::CMD_VECTOR, '0, -ONE_Q, -ONE_Q));
    directed.push_back(mk(crv_pkg::CMD_VECTOR, '0, '0, '0));
    directed.push_back(mk(crv_pkg::CMD_VECTOR, MAX_Q, MAX_Q, MAX_Q));
    directed.push_back(mk(crv_pkg::CMD_VECTOR, MIN_Q, MIN_Q, MIN_Q));
    directed.push_back(mk(crv_pkg::CMD_VECTOR, '0, MAX_Q, MIN_Q));
    directed.push_back(mk(crv_pkg::CMD_VECTOR, 32'($urandom()), MIN_Q, MAX_Q));
    directed.push_back(mk(crv_pkg::CMD_VECTOR, PI_Q, ONE_Q, -ONE_Q));
    foreach (directed[i]) send_beat(directed[i]);
    wait_drained();

    for (int n = 0; n < N_RAND; n++) begin
      calm = (n >= N_RAND - N_CALM) || ((n / 60) % 3 == 2);
      if (!calm && $urandom_range(0, 4) == 0) idle_gap($urandom_range(1, 7));
      if (n == N_RAND / 2) wait_drained();
      send_beat(random_beat());
    end
    wait_drained();
    repeat (PIPE_LATENCY + 4) @(posedge clk);

    if (cordic_sb.faults == 0 && cordic_sb.outstanding() == 0) begin
      $display("cordic_rotate_vector_unit regression: pass");
    end else begin
      $display("cordic_rotate_vector_unit regression: fail");
    end
    $finish;
  end
endmodule
